/* rtl/fdf_pkg.sv */
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types, constants and the hash step of the duplicate frame filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdf_pkg;

   // ring geometry default
   localparam int CACHE_ENTRIES_DEF = 8;

   // payload widths
   localparam int BYTE_W     = 8;
   localparam int HASH_W     = 16;
   localparam int STAMP_W    = 32;
   localparam int INTERVAL_W = 16;

   // hash multiplier 31 = 2^5 - 1
   localparam int HASH_SHIFT = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_DUP_INTERVAL = '0;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd30;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } fdf_state_type;

   // one ring entry
   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // ring access command
   typedef struct packed {
      logic      rd_en;
      logic      wr_en;
      entry_type wr_entry;
   } ring_cmd_type;

   // ring read data, registered: available in the cycle after the read
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } ring_rsp_type;

   // h * 31 + byte, wrapping to 16 bits
   function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] data);
      logic [HASH_W-1:0] scaled;
      scaled = (acc << HASH_SHIFT) - acc;
      return scaled + HASH_W'(data);
   endfunction

endpackage

`default_nettype wire

/* rtl/fdf_ring.sv */
// ----------------------------------------------------------------------------
// fdf_ring
// Ring of recent (hash, timestamp) entries in a synchronous memory, with a
// valid flag per entry cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_ring #(
   parameter int CACHE_ENTRIES = fdf_pkg::CACHE_ENTRIES_DEF,
   parameter int IDXW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fdf_pkg::ring_cmd_type ring_cmd,
   input  wire logic [IDXW-1:0]      rd_addr,
   input  wire logic [IDXW-1:0]      wr_addr,
   output fdf_pkg::ring_rsp_type     ring_rsp
);

   fdf_pkg::entry_type mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;
   fdf_pkg::entry_type rd_entry_ff;
   logic rd_valid_ff;

   // entry storage, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (ring_cmd.wr_en) begin
         mem[wr_addr] <= ring_cmd.wr_entry;
      end
      if (ring_cmd.rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ring_cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ring_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign ring_rsp.valid = rd_valid_ff;
   assign ring_rsp.entry = rd_entry_ff;

endmodule

`default_nettype wire

/* rtl/fdf_ctrl.sv */
// ----------------------------------------------------------------------------
// fdf_ctrl
// Hash accumulator and sequencer: scans the ring one entry a cycle on the
// final byte, decides duplicate status and records new frames.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_ctrl #(
   parameter int CACHE_ENTRIES = fdf_pkg::CACHE_ENTRIES_DEF,
   parameter int IDXW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fdf_pkg::BYTE_W-1:0]       req_info_byte,
   input  wire logic                             req_last_byte,
   input  wire logic [fdf_pkg::STAMP_W-1:0]      req_now_seconds,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_is_duplicate,
   output logic [fdf_pkg::HASH_W-1:0]            rsp_frame_hash,
   input  wire logic [fdf_pkg::INTERVAL_W-1:0]   dup_interval,
   output fdf_pkg::ring_cmd_type                 ring_cmd,
   output logic [IDXW-1:0]                       rd_addr,
   output logic [IDXW-1:0]                       wr_addr,
   input  wire fdf_pkg::ring_rsp_type            ring_rsp
);

   localparam int CNTW = $clog2(CACHE_ENTRIES + 1);

   fdf_pkg::fdf_state_type state_ff, state_in;

   logic [fdf_pkg::HASH_W-1:0]  acc_ff;
   logic [fdf_pkg::HASH_W-1:0]  key_hash_ff;
   logic [fdf_pkg::STAMP_W-1:0] key_now_ff;
   logic [CNTW-1:0]             cnt_ff;
   logic                        pend_ff;
   logic                        dup_ff;
   logic [IDXW-1:0]             ptr_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_dup_ff;
   logic [fdf_pkg::HASH_W-1:0]  rsp_hash_ff;

   logic                        accept;
   logic [fdf_pkg::HASH_W-1:0]  hash_next;
   logic                        scan_end;
   logic                        slot_free;
   logic                        load;
   logic                        hit;
   logic [fdf_pkg::STAMP_W-1:0] age;

   assign accept    = req_valid && req_ready;
   assign hash_next = fdf_pkg::hash_step(acc_ff, req_info_byte);
   assign scan_end  = (cnt_ff == CNTW'(CACHE_ENTRIES)) && !pend_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // compare of the entry read in the previous cycle
   assign age = key_now_ff - ring_rsp.entry.stamp;
   assign hit = pend_ff && ring_rsp.valid && (ring_rsp.entry.hash == key_hash_ff) &&
                (age < {{(fdf_pkg::STAMP_W - fdf_pkg::INTERVAL_W){1'b0}}, dup_interval});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdf_pkg::ST_IDLE: begin
            if (accept && req_last_byte) begin
               state_in = fdf_pkg::ST_SCAN;
            end
         end
         fdf_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = fdf_pkg::ST_DONE;
            end
         end
         fdf_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = fdf_pkg::ST_IDLE;
            end
         end
         default: state_in = fdf_pkg::ST_IDLE;
      endcase
   end

   // state outputs and ring commands
   always_comb begin
      req_ready         = (state_ff == fdf_pkg::ST_IDLE);
      load              = (state_ff == fdf_pkg::ST_DONE) && slot_free;
      ring_cmd.rd_en    = (state_ff == fdf_pkg::ST_SCAN) && (cnt_ff < CNTW'(CACHE_ENTRIES));
      ring_cmd.wr_en    = load && !dup_ff;
      ring_cmd.wr_entry.hash  = key_hash_ff;
      ring_cmd.wr_entry.stamp = key_now_ff;
      rd_addr           = cnt_ff[IDXW-1:0];
      wr_addr           = ptr_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdf_pkg::ST_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= ring_cmd.rd_en;

         // running hash, restarted after the final byte
         if (accept) begin
            acc_ff <= req_last_byte ? '0 : hash_next;
         end

         // scan counter and match flag
         if (accept && req_last_byte) begin
            cnt_ff <= '0;
            dup_ff <= 1'b0;
         end else begin
            if (ring_cmd.rd_en) begin
               cnt_ff <= cnt_ff + CNTW'(1);
            end
            if (hit) begin
               dup_ff <= 1'b1;
            end
         end

         // ring pointer advances on each recorded frame
         if (ring_cmd.wr_en) begin
            ptr_ff <= (ptr_ff == IDXW'(CACHE_ENTRIES - 1)) ? '0 : ptr_ff + IDXW'(1);
         end

         // result beat
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         key_hash_ff <= hash_next;
         key_now_ff  <= req_now_seconds;
      end
      if (load) begin
         rsp_dup_ff  <= dup_ff;
         rsp_hash_ff <= key_hash_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_frame_hash   = rsp_hash_ff;

endmodule

`default_nettype wire

/* rtl/frame_duplicate_filter_core.sv */
// ----------------------------------------------------------------------------
// frame_duplicate_filter_core
// Hash-based duplicate frame filter with a ring of recent frame entries.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one information byte per beat, req_last_byte marks the
//   final byte, req_now_seconds is sampled with the final byte.
//   rsp_ channel: one beat per frame with the frame hash and a duplicate
//   flag; a set flag means the frame should be dropped.
//   APB port: register 0 at byte address 0 holds the duplicate interval in
//   seconds (reset 30).
//   A non-final byte is taken and gives no result. The final byte starts
//   a scan of the ring memory, one entry read per cycle through its single
//   read port; the result is then loaded into the output register from the
//   done state, and no byte is taken until it has been loaded.
//   A new frame is recorded at the ring pointer in the same cycle as its
//   result is loaded.
//   Reset clears the hash, the ring pointer and all entry valid flags; no
//   clearing pass is needed. A stalled result waits in the output register;
//   bytes are still taken up to the next final byte, whose result then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_duplicate_filter_core #(
   parameter int CACHE_ENTRIES = fdf_pkg::CACHE_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [fdf_pkg::BYTE_W-1:0]     req_info_byte,
   input  wire logic                           req_last_byte,
   input  wire logic [fdf_pkg::STAMP_W-1:0]    req_now_seconds,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_is_duplicate,
   output logic [fdf_pkg::HASH_W-1:0]          rsp_frame_hash,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [fdf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [fdf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fdf_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int IDXW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   logic [fdf_pkg::INTERVAL_W-1:0] dup_interval_ff;
   logic                           reg_hit;
   fdf_pkg::ring_cmd_type          ring_cmd;
   fdf_pkg::ring_rsp_type          ring_rsp;
   logic [IDXW-1:0]                rd_addr;
   logic [IDXW-1:0]                wr_addr;

   // register decode
   assign pready  = 1'b1;
   assign reg_hit = (paddr[fdf_pkg::CSR_ADDR_W-1:2] == fdf_pkg::REG_DUP_INTERVAL);

   // duplicate interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         dup_interval_ff <= fdf_pkg::INTERVAL_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         dup_interval_ff <= pwdata[fdf_pkg::INTERVAL_W-1:0];
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      if (reg_hit) begin
         prdata = fdf_pkg::CSR_DATA_W'(dup_interval_ff);
      end
   end

   fdf_ctrl #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .IDXW          (IDXW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_info_byte    (req_info_byte),
      .req_last_byte    (req_last_byte),
      .req_now_seconds  (req_now_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_duplicate (rsp_is_duplicate),
      .rsp_frame_hash   (rsp_frame_hash),
      .dup_interval     (dup_interval_ff),
      .ring_cmd         (ring_cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .ring_rsp         (ring_rsp)
   );

   fdf_ring #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .IDXW          (IDXW)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_cmd (ring_cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .ring_rsp (ring_rsp)
   );

`ifndef SYNTHESIS
   // a final byte starts a scan, so no beat is taken in the next cycle
   a_scan_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_byte) |=> !req_ready)
      else $error("byte accepted right after a final byte");

   // no byte is taken while the ring is being read
   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      ring_cmd.rd_en |-> !req_ready)
      else $error("ring read while input is open");

   // recording a frame goes with loading its result
   a_write_loads_result: assert property (@(posedge clock) disable iff (reset)
      ring_cmd.wr_en |=> (rsp_valid && !rsp_is_duplicate))
      else $error("ring write without a matching result beat");
`endif

endmodule

`default_nettype wire
